// ----- rtl/cc20_pkg.sv -----
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, register indexes and constants of the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [7:0] data_in;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       message_end_out;
   } rsp_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_KEY_0_7    = 3'd0;
   localparam logic [2:0] CSR_KEY_8_15   = 3'd1;
   localparam logic [2:0] CSR_KEY_16_23  = 3'd2;
   localparam logic [2:0] CSR_KEY_24_31  = 3'd3;
   localparam logic [2:0] CSR_NONCE_0_7  = 3'd4;
   localparam logic [2:0] CSR_NONCE_8_11 = 3'd5;

   localparam int unsigned CsrWidth = 64;

   // Depth of the queue between the front and the keystream core.
   localparam int unsigned QueueDepth = 2;

   // 20 rounds, each done as four steps of a quarter of a quarter round.
   localparam int unsigned StepsPerBlock = 80;

   localparam word_type SIGMA [4] = '{
      32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
   };

   // State index of one quarter-round operand. Role 0..3 is a, b, c, d.
   // Diagonal rounds shift each row by its row number.
   function automatic logic [3:0] qr_index(input logic       diag,
                                           input logic [1:0] lane,
                                           input logic [1:0] role);
      logic [1:0] col;
      col = diag ? 2'(lane + role) : lane;
      return {role, col};
   endfunction

endpackage

// ----- rtl/cc20_front.sv -----
// ----------------------------------------------------------------------------
// cc20_front
// Input side: takes request beats and holds them in a short queue for the core.
// ----------------------------------------------------------------------------
module cc20_front #(
   parameter int unsigned Depth = cc20_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cc20_pkg::req_type req_payload,
   output logic             q_valid,
   output cc20_pkg::req_type q_head,
   input  logic             q_pop
);

   localparam int unsigned AddrWidth  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);

   cc20_pkg::req_type      slot_ff [Depth];
   logic [AddrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AddrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign req_stall = (count_ff == CountWidth'(Depth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_head    = slot_ff[rd_ptr_ff];

   function automatic logic [AddrWidth-1:0] next_ptr(input logic [AddrWidth-1:0] p);
      return (p == AddrWidth'(Depth - 1)) ? '0 : AddrWidth'(p + 1'b1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CountWidth'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CountWidth'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_payload;
      end
   end

endmodule

// ----- rtl/cc20_core.sv -----
// ----------------------------------------------------------------------------
// cc20_core
// Back side: computes keystream blocks and XORs queued bytes with them.
// ----------------------------------------------------------------------------
module cc20_core (
   input  logic               clock,
   input  logic               reset,
   input  logic [255:0]       key,
   input  logic [95:0]        nonce,
   input  logic               q_valid,
   input  cc20_pkg::req_type  q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cc20_pkg::rsp_type  rsp_payload
);

   typedef enum logic [2:0] {
      ST_RUN   = 3'b001,
      ST_ROUND = 3'b010,
      ST_FINAL = 3'b100
   } state_type;

   localparam int unsigned StepWidth = $clog2(cc20_pkg::StepsPerBlock);

   state_type            fsm_ff, fsm_in;
   cc20_pkg::word_type   st_ff [16];
   cc20_pkg::word_type   st_in [16];
   cc20_pkg::word_type   start [16];
   cc20_pkg::word_type   round_st [16];
   logic [StepWidth-1:0] step_ff, step_in;
   logic [31:0]          counter_ff, counter_in;
   logic [5:0]           pos_ff, pos_in;
   logic                 have_ff, have_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   cc20_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 out_free;
   logic                 emit;
   logic                 start_block;
   cc20_pkg::word_type   ks_word;
   logic [7:0]           ks_byte;

   // Initial block state from constants, key, counter and nonce.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         start[i] = cc20_pkg::SIGMA[i];
      end
      for (int i = 0; i < 8; i++) begin
         start[4 + i] = key[32*i +: 32];
      end
      start[12] = counter_ff;
      for (int i = 0; i < 3; i++) begin
         start[13 + i] = nonce[32*i +: 32];
      end
   end

   // One quarter of a quarter round on all four lanes at once. Odd rounds
   // work on the diagonals.
   always_comb begin
      logic [3:0]         ia, ib, ic, id;
      cc20_pkg::word_type wa, wb, wc, wd, sum, mix;
      for (int k = 0; k < 16; k++) begin
         round_st[k] = st_ff[k];
      end
      for (int lane = 0; lane < 4; lane++) begin
         ia  = cc20_pkg::qr_index(step_ff[2], 2'(lane), 2'd0);
         ib  = cc20_pkg::qr_index(step_ff[2], 2'(lane), 2'd1);
         ic  = cc20_pkg::qr_index(step_ff[2], 2'(lane), 2'd2);
         id  = cc20_pkg::qr_index(step_ff[2], 2'(lane), 2'd3);
         wa  = st_ff[ia];
         wb  = st_ff[ib];
         wc  = st_ff[ic];
         wd  = st_ff[id];
         sum = '0;
         mix = '0;
         case (step_ff[1:0])
            2'd0: begin
               sum = wa + wb;
               mix = wd ^ sum;
               round_st[ia] = sum;
               round_st[id] = {mix[15:0], mix[31:16]};
            end
            2'd1: begin
               sum = wc + wd;
               mix = wb ^ sum;
               round_st[ic] = sum;
               round_st[ib] = {mix[19:0], mix[31:20]};
            end
            2'd2: begin
               sum = wa + wb;
               mix = wd ^ sum;
               round_st[ia] = sum;
               round_st[id] = {mix[23:0], mix[31:24]};
            end
            default: begin
               sum = wc + wd;
               mix = wb ^ sum;
               round_st[ic] = sum;
               round_st[ib] = {mix[24:0], mix[31:25]};
            end
         endcase
      end
   end

   assign ks_word     = st_ff[pos_ff[5:2]];
   assign ks_byte     = ks_word[{pos_ff[1:0], 3'b000} +: 8];
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign start_block = (fsm_ff == ST_RUN) && q_valid && (pos_ff == '0) && !have_ff;
   assign emit        = (fsm_ff == ST_RUN) && q_valid && !start_block && out_free;
   assign q_pop       = emit;

   always_comb begin
      fsm_in       = fsm_ff;
      step_in      = step_ff;
      counter_in   = counter_ff;
      pos_in       = pos_ff;
      have_in      = have_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_in       = rsp_ff;
      for (int k = 0; k < 16; k++) begin
         st_in[k] = st_ff[k];
      end
      unique case (fsm_ff)
         ST_RUN: begin
            if (start_block) begin
               for (int k = 0; k < 16; k++) begin
                  st_in[k] = start[k];
               end
               step_in = '0;
               fsm_in  = ST_ROUND;
            end else if (emit) begin
               rsp_valid_in           = 1'b1;
               rsp_in.data_out        = q_head.data_in ^ ks_byte;
               rsp_in.message_end_out = q_head.message_end;
               if (q_head.message_end) begin
                  counter_in = 32'd1;
                  pos_in     = '0;
                  have_in    = 1'b0;
               end else begin
                  pos_in = 6'(pos_ff + 1'b1);
                  if (pos_ff == 6'd63) begin
                     counter_in = 32'(counter_ff + 1'b1);
                     have_in    = 1'b0;
                  end
               end
            end
         end
         ST_ROUND: begin
            for (int k = 0; k < 16; k++) begin
               st_in[k] = round_st[k];
            end
            step_in = StepWidth'(step_ff + 1'b1);
            if (step_ff == StepWidth'(cc20_pkg::StepsPerBlock - 1)) begin
               fsm_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            // The counter has not moved since the block was loaded.
            for (int k = 0; k < 16; k++) begin
               st_in[k] = st_ff[k] + start[k];
            end
            have_in = 1'b1;
            fsm_in  = ST_RUN;
         end
         default: begin
            fsm_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_RUN;
         step_ff      <= '0;
         counter_ff   <= 32'd1;
         pos_ff       <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         step_ff      <= step_in;
         counter_ff   <= counter_in;
         pos_ff       <= pos_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      for (int k = 0; k < 16; k++) begin
         st_ff[k] <= st_in[k];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/chacha20_stream_cipher.sv -----
// Path: an accepted byte passes through a queue slot and the response register
// when a keystream block is at hand; the first byte of each 64-byte block also
// waits for its block to be computed. Throughput: one byte per cycle within a
// block while the output is not stalled; a block takes a state load, 80 round
// steps (one quarter of a quarter round on four lanes per cycle) and a final add.
// Reset: synchronous, active high; clears the queue, sets the block counter
// to 1, the byte position to 0 and all configuration registers to 0.
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 byte stream cipher with key and nonce held in write-only registers.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher #(
   parameter int unsigned QueueDepth = cc20_pkg::QueueDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cc20_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cc20_pkg::rsp_type             rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [2:0]                    csr_index,
   input  logic [cc20_pkg::CsrWidth-1:0] csr_wr_data
);

   logic [63:0]       key_ff [4];
   logic [63:0]       nonce_lo_ff;
   logic [31:0]       nonce_hi_ff;
   logic              q_valid;
   logic              q_pop;
   cc20_pkg::req_type q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= '0;
         end
         nonce_lo_ff <= '0;
         nonce_hi_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cc20_pkg::CSR_KEY_0_7:    key_ff[0]   <= csr_wr_data;
            cc20_pkg::CSR_KEY_8_15:   key_ff[1]   <= csr_wr_data;
            cc20_pkg::CSR_KEY_16_23:  key_ff[2]   <= csr_wr_data;
            cc20_pkg::CSR_KEY_24_31:  key_ff[3]   <= csr_wr_data;
            cc20_pkg::CSR_NONCE_0_7:  nonce_lo_ff <= csr_wr_data;
            cc20_pkg::CSR_NONCE_8_11: nonce_hi_ff <= csr_wr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   cc20_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop)
   );

   cc20_core u_core (
      .clock       (clock),
      .reset       (reset),
      .key         ({key_ff[3], key_ff[2], key_ff[1], key_ff[0]}),
      .nonce       ({nonce_hi_ff, nonce_lo_ff}),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
